// ===== hdl/evlx_pkg.sv =====
// Shared types and constants for the Ethernet/VLAN/IPv4/L4 header extractor.
// No dependencies; imported by every module of the block.
`default_nettype none

package evlx_pkg;

  localparam int HDR_DEPTH = 52;
  localparam int POS_W     = 6;

  localparam logic [POS_W-1:0] POS_MAX = 6'd63;

  localparam int IP_OFS_UNTAGGED = 14;
  localparam int IP_OFS_TAGGED   = 18;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_VLAN = 16'h8100;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [1:0] STATUS_UNTAGGED   = 2'd0;
  localparam logic [1:0] STATUS_TAGGED     = 2'd1;
  localparam logic [1:0] STATUS_NOT_PARSED = 2'd2;

  typedef logic [HDR_DEPTH-1:0][7:0] frame_t;

  typedef struct packed {
    logic [47:0] mac_first;
    logic [47:0] mac_second;
    logic [15:0] vlan_tag;
    logic [15:0] ether_type;
    logic [7:0]  ip_tos;
    logic [7:0]  ip_proto;
    logic [31:0] ip_source;
    logic [31:0] ip_destination;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [3:0]  tcp_flag_bits;
    logic [1:0]  status;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/evlx_capture.sv =====
// Header byte store with fill count; presents the frame including the current byte.
// Depends on evlx_pkg.
`default_nettype none

module evlx_capture
  import evlx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output frame_t          frame
);

  logic [7:0]       store [HDR_DEPTH];
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;

  always_comb begin
    if (last_byte) begin
      pos_next = '0;
    end else if (pos == POS_MAX) begin
      pos_next = POS_MAX;
    end else begin
      pos_next = pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

  // Bytes past the fill count are stale from an earlier frame; mask them below.
  always_ff @(posedge clk) begin
    if (accept && (pos < POS_W'(HDR_DEPTH))) begin
      store[pos] <= data_byte;
    end
  end

  always_comb begin
    for (int i = 0; i < HDR_DEPTH; i++) begin
      if (POS_W'(i) == pos) begin
        frame[i] = data_byte;
      end else if (POS_W'(i) < pos) begin
        frame[i] = store[i];
      end else begin
        frame[i] = '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/evlx_extract.sv =====
// Field decode of a captured frame: ethertype, VLAN, IPv4 and TCP/UDP fields.
// Depends on evlx_pkg.
`default_nettype none

module evlx_extract
  import evlx_pkg::*;
(
  input  wire frame_t frame,
  output result_t     result
);

  function automatic logic [7:0] ip_byte(input frame_t fr, input logic tg, input int k);
    return tg ? fr[IP_OFS_TAGGED + k] : fr[IP_OFS_UNTAGGED + k];
  endfunction

  logic [15:0] outer_type;
  logic        vlan_hit;
  logic        ipv4;
  logic        parse;
  logic [7:0]  proto;
  logic        is_tcp;
  logic        has_ports;
  logic [7:0]  flag_byte;

  always_comb begin
    outer_type = {frame[12], frame[13]};
    vlan_hit   = (outer_type == ETH_VLAN);
    ipv4       = (outer_type == ETH_IPV4);
    parse      = vlan_hit || ipv4;
    proto      = parse ? ip_byte(frame, vlan_hit, 9) : 8'd0;
    is_tcp     = parse && (proto == PROTO_TCP);
    has_ports  = parse && ((proto == PROTO_TCP) || (proto == PROTO_UDP));
    flag_byte  = ip_byte(frame, vlan_hit, 33);

    result.mac_first  = {frame[0], frame[1], frame[2], frame[3], frame[4], frame[5]};
    result.mac_second = {frame[6], frame[7], frame[8], frame[9], frame[10], frame[11]};
    result.vlan_tag   = vlan_hit ? {frame[14], frame[15]} : 16'd0;
    result.ether_type = vlan_hit ? {frame[16], frame[17]} : outer_type;
    result.ip_tos     = parse ? ip_byte(frame, vlan_hit, 1) : 8'd0;
    result.ip_proto   = proto;
    result.ip_source  = parse ? {ip_byte(frame, vlan_hit, 12), ip_byte(frame, vlan_hit, 13),
                                 ip_byte(frame, vlan_hit, 14), ip_byte(frame, vlan_hit, 15)}
                              : 32'd0;
    result.ip_destination = parse ?
                            {ip_byte(frame, vlan_hit, 16), ip_byte(frame, vlan_hit, 17),
                             ip_byte(frame, vlan_hit, 18), ip_byte(frame, vlan_hit, 19)}
                                  : 32'd0;
    result.source_port = has_ports ?
                         {ip_byte(frame, vlan_hit, 20), ip_byte(frame, vlan_hit, 21)}
                                   : 16'd0;
    result.destination_port = has_ports ?
                              {ip_byte(frame, vlan_hit, 22), ip_byte(frame, vlan_hit, 23)}
                              : 16'd0;
    // FIN, SYN, RST in place; ACK moves down from bit 4.
    result.tcp_flag_bits = is_tcp ? {flag_byte[4], flag_byte[2], flag_byte[1], flag_byte[0]}
                                  : 4'd0;
    if (vlan_hit) begin
      result.status = STATUS_TAGGED;
    end else if (ipv4) begin
      result.status = STATUS_UNTAGGED;
    end else begin
      result.status = STATUS_NOT_PARSED;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/evlx_out_buf.sv =====
// Result register with one skid entry, decoupling the byte input from output stall.
// Depends on evlx_pkg.
`default_nettype none

module evlx_out_buf
  import evlx_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/eth_vlan_ipv4_l4_header_extract_core.sv =====
// Ethernet / VLAN / IPv4 / TCP-UDP header extractor, top level.
// Depends on evlx_pkg, evlx_capture, evlx_extract, evlx_out_buf.
//
// Usage:
//   Input channel (in_valid / in_stall): one frame byte per transaction,
//   starting at the Ethernet header; last_byte marks the final byte.
//   Output channel (out_valid / out_stall): one result transaction per
//   frame, carrying the MAC addresses, ethertype, VLAN tag, IPv4 fields,
//   L4 ports, TCP flags and a parse status.
//   Throughput: one byte per cycle while in_stall is low, back to back
//   across frame boundaries; the first byte of the next frame may follow
//   the last byte directly, and the result is registered as it is taken.
//   The result is decoded in one pass from the 52-byte header store and
//   the incoming byte; bytes past the fill count read as zero, so the
//   store never needs a clearing pass.
//   Stall: a stalled result holds in the output register; one more result
//   parks in a skid entry, and only then does in_stall rise.
//   Reset (rst, synchronous): drop any pending result, return the byte
//   position to zero; the block accepts input in the next cycle.
`default_nettype none

module eth_vlan_ipv4_l4_header_extract_core
  import evlx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [47:0]      mac_first,
  output logic [47:0]      mac_second,
  output logic [15:0]      vlan_tag,
  output logic [15:0]      ether_type,
  output logic [7:0]       ip_tos,
  output logic [7:0]       ip_proto,
  output logic [31:0]      ip_source,
  output logic [31:0]      ip_destination,
  output logic [15:0]      source_port,
  output logic [15:0]      destination_port,
  output logic [3:0]       tcp_flag_bits,
  output logic [1:0]       status
);

  logic    accept;
  logic    buf_full;
  frame_t  frame;
  result_t decoded;
  result_t held;

  // Take a byte whenever the skid entry is free.
  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  evlx_capture u_capture (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .frame     (frame)
  );

  evlx_extract u_extract (
    .frame  (frame),
    .result (decoded)
  );

  // Only the last byte of a frame produces a result transaction.
  evlx_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && last_byte),
    .push_data (decoded),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (held)
  );

  assign mac_first        = held.mac_first;
  assign mac_second       = held.mac_second;
  assign vlan_tag         = held.vlan_tag;
  assign ether_type       = held.ether_type;
  assign ip_tos           = held.ip_tos;
  assign ip_proto         = held.ip_proto;
  assign ip_source        = held.ip_source;
  assign ip_destination   = held.ip_destination;
  assign source_port      = held.source_port;
  assign destination_port = held.destination_port;
  assign tcp_flag_bits    = held.tcp_flag_bits;
  assign status           = held.status;

endmodule

`default_nettype wire

// ===== hdl/evlx_checker.sv =====
// Port-level checks for the header extractor, bound to the top level.
// Depends on evlx_pkg and eth_vlan_ipv4_l4_header_extract_core.
`default_nettype none

module evlx_checker
  import evlx_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] vlan_tag,
  input wire logic [7:0]  ip_proto,
  input wire logic [31:0] ip_source,
  input wire logic [15:0] source_port,
  input wire logic [3:0]  tcp_flag_bits,
  input wire logic [1:0]  status
);

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // Input stalls only when a result is waiting behind a stalled one.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && $past(out_valid))
    else $error("input stalled with no pending result");

  a_unparsed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_NOT_PARSED) |->
      vlan_tag == 16'd0 && ip_proto == 8'd0 && ip_source == 32'd0 && source_port == 16'd0)
    else $error("unparsed frame carries IP fields");

  a_flags_tcp_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && (ip_proto != PROTO_TCP) |-> tcp_flag_bits == 4'd0)
    else $error("TCP flags on non-TCP frame");

endmodule

bind eth_vlan_ipv4_l4_header_extract_core evlx_checker u_evlx_checker (.*);

`default_nettype wire

// ===== test/eth_vlan_ipv4_l4_header_extract_core_tb.sv =====
// Self-checking testbench for the Ethernet/VLAN/IPv4/L4 header extractor.
// Depends on evlx_pkg and eth_vlan_ipv4_l4_header_extract_core; needs no files.
// Drives frames byte by byte and checks every result against a built-in predictor.
module eth_vlan_ipv4_l4_header_extract_core_tb
  import evlx_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // Directed frame recipe: byte pattern plus the header fields stamped over it.
  // When known is set, the result is typed in here instead of being predicted.
  typedef struct {
    int          len;
    bit          rnd;
    logic [7:0]  fill;
    logic [15:0] etype;
    logic [15:0] inner;
    logic [7:0]  proto;
    logic [7:0]  tflags;
    bit          known;
    result_t     val;
  } frame_recipe_t;

  // One entry per frame sent; tells the predictor whether a typed result applies.
  typedef struct {
    bit      known;
    result_t val;
  } typed_hdr_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [47:0] mac_first;
  logic [47:0] mac_second;
  logic [15:0] vlan_tag;
  logic [15:0] ether_type;
  logic [7:0]  ip_tos;
  logic [7:0]  ip_proto;
  logic [31:0] ip_source;
  logic [31:0] ip_destination;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic [3:0]  tcp_flag_bits;
  logic [1:0]  status;

  // Predictor copy of the block state: header store and byte position.
  logic [7:0]    hdr_store [HDR_DEPTH];
  logic [POS_W-1:0] hdr_pos;

  result_t       hdr_expect [$];
  typed_hdr_t    typed_hdrs [$];
  logic [7:0]    frame_buf [$];
  frame_recipe_t recipes [15];

  logic idle_on;
  int   stall_left;
  int   err_count;
  int   bytes_taken;
  int   frames_sent;
  int   status_seen [4];

  eth_vlan_ipv4_l4_header_extract_core u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .mac_first       (mac_first),
    .mac_second      (mac_second),
    .vlan_tag        (vlan_tag),
    .ether_type      (ether_type),
    .ip_tos          (ip_tos),
    .ip_proto        (ip_proto),
    .ip_source       (ip_source),
    .ip_destination  (ip_destination),
    .source_port     (source_port),
    .destination_port(destination_port),
    .tcp_flag_bits   (tcp_flag_bits),
    .status          (status)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Read a stored header byte; offsets past the store read as zero.
  function automatic logic [7:0] hdr_at(int off);
    return (off < HDR_DEPTH) ? hdr_store[off] : 8'h00;
  endfunction

  // Big-endian field of up to six bytes, first byte most significant.
  function automatic logic [47:0] hdr_field(int off, int n);
    logic [47:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v = {v[39:0], hdr_at(off + i)};
    return v;
  endfunction

  // Absorb one accepted byte; on the last byte of a frame, decode the header,
  // queue the expected result and clear the store for the next frame.
  function automatic void track_byte(logic [7:0] b, logic l);
    result_t    r;
    typed_hdr_t t;
    logic [15:0] et;
    logic [7:0]  f;
    int          ip;
    if (hdr_pos < HDR_DEPTH) hdr_store[hdr_pos] = b;
    if (hdr_pos != POS_MAX) hdr_pos++;
    if (!l) return;

    r = '0;
    ip = 0;
    r.mac_first  = hdr_field(0, 6);
    r.mac_second = hdr_field(6, 6);
    r.status     = STATUS_NOT_PARSED;
    et = 16'(hdr_field(12, 2));
    if (et == ETH_IPV4) begin
      ip = IP_OFS_UNTAGGED;
      r.status = STATUS_UNTAGGED;
    end else if (et == ETH_VLAN) begin
      // inner ethertype is reported as is; the IP header is assumed regardless
      r.vlan_tag = 16'(hdr_field(14, 2));
      et = 16'(hdr_field(16, 2));
      ip = IP_OFS_TAGGED;
      r.status = STATUS_TAGGED;
    end
    r.ether_type = et;
    if (ip != 0) begin
      r.ip_tos         = hdr_at(ip + 1);
      r.ip_proto       = hdr_at(ip + 9);
      r.ip_source      = 32'(hdr_field(ip + 12, 4));
      r.ip_destination = 32'(hdr_field(ip + 16, 4));
      if (r.ip_proto == PROTO_TCP || r.ip_proto == PROTO_UDP) begin
        r.source_port      = 16'(hdr_field(ip + 20, 2));
        r.destination_port = 16'(hdr_field(ip + 22, 2));
        if (r.ip_proto == PROTO_TCP) begin
          f = hdr_at(ip + 33);
          r.tcp_flag_bits = {f[4], f[2:0]};
        end
      end
    end

    t = typed_hdrs.pop_front();
    hdr_expect.push_back(t.known ? t.val : r);
    foreach (hdr_store[i]) hdr_store[i] = 8'h00;
    hdr_pos = '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_count++;
    $display("[%0t] MISMATCH %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (hdr_expect.size() == 0) begin
      flag_mismatch("result with nothing pending, status", got.status, 0);
      return;
    end
    want = hdr_expect.pop_front();
    status_seen[got.status]++;
    if (got.mac_first !== want.mac_first)
      flag_mismatch("mac_first", got.mac_first, want.mac_first);
    if (got.mac_second !== want.mac_second)
      flag_mismatch("mac_second", got.mac_second, want.mac_second);
    if (got.vlan_tag !== want.vlan_tag)
      flag_mismatch("vlan_tag", got.vlan_tag, want.vlan_tag);
    if (got.ether_type !== want.ether_type)
      flag_mismatch("ether_type", got.ether_type, want.ether_type);
    if (got.ip_tos !== want.ip_tos)
      flag_mismatch("ip_tos", got.ip_tos, want.ip_tos);
    if (got.ip_proto !== want.ip_proto)
      flag_mismatch("ip_proto", got.ip_proto, want.ip_proto);
    if (got.ip_source !== want.ip_source)
      flag_mismatch("ip_source", got.ip_source, want.ip_source);
    if (got.ip_destination !== want.ip_destination)
      flag_mismatch("ip_destination", got.ip_destination, want.ip_destination);
    if (got.source_port !== want.source_port)
      flag_mismatch("source_port", got.source_port, want.source_port);
    if (got.destination_port !== want.destination_port)
      flag_mismatch("destination_port", got.destination_port, want.destination_port);
    if (got.tcp_flag_bits !== want.tcp_flag_bits)
      flag_mismatch("tcp_flag_bits", got.tcp_flag_bits, want.tcp_flag_bits);
    if (got.status !== want.status)
      flag_mismatch("status", got.status, want.status);
  endtask

  // Sample both channels at the edge: outputs first, then feed the predictor
  // with the byte that this edge takes. A result never comes out on the edge
  // that takes its last byte, so the order cannot matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        check_result({mac_first, mac_second, vlan_tag, ether_type, ip_tos, ip_proto,
                      ip_source, ip_destination, source_port, destination_port,
                      tcp_flag_bits, status});
      if (in_valid && !in_stall) begin
        bytes_taken++;
        track_byte(data_byte, last_byte);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall in random bursts while idling is on
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Present one byte and hold it until the block takes it. Optionally drop
  // valid for a short burst first, so gaps land anywhere inside a frame.
  task automatic put_byte(logic [7:0] b, logic l);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do @(posedge clk); while (in_stall);
  endtask

  // Send frame_buf as one frame; register the typed result (if any) first.
  task automatic send_frame(bit known, result_t val);
    typed_hdrs.push_back('{known, val});
    foreach (frame_buf[i]) put_byte(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
  endtask

  // Hold the sender until every queued result has come out (bounded).
  task automatic hold_until_drained();
    int n;
    in_valid <= 1'b0;
    n = 0;
    do begin
      @(posedge clk);
      n++;
    end while (hdr_expect.size() != 0 && n < 10000);
  endtask

  function automatic void poke(int idx, logic [7:0] v);
    if (idx < frame_buf.size()) frame_buf[idx] = v;
  endfunction

  // Stamp ethertype, inner ethertype, protocol and TCP flag byte into the frame,
  // wherever the frame is long enough to hold them.
  function automatic void stamp_headers(logic [15:0] et, logic [15:0] inner,
                                        logic [7:0] proto, logic [7:0] tflags);
    int ip;
    ip = (et == ETH_VLAN) ? IP_OFS_TAGGED : IP_OFS_UNTAGGED;
    poke(12, et[15:8]);
    poke(13, et[7:0]);
    if (et == ETH_VLAN) begin
      poke(16, inner[15:8]);
      poke(17, inner[7:0]);
    end
    poke(ip + 9, proto);
    poke(ip + 33, tflags);
  endfunction

  // Mostly well-formed IPv4 frames (plain or tagged) with random content;
  // the rest is other ethertypes, runts and long frames.
  task automatic build_random_frame();
    int          kind;
    int          ip;
    int          len;
    int          pick;
    logic [15:0] et;
    logic [15:0] inner;
    logic [7:0]  proto;
    kind  = $urandom_range(0, 9);
    pick  = $urandom_range(0, 9);
    proto = (pick < 4) ? PROTO_TCP : (pick < 7) ? PROTO_UDP : 8'($urandom);
    inner = ($urandom_range(0, 3) == 0) ? 16'($urandom) : ETH_IPV4;
    if (kind <= 3) et = ETH_IPV4;
    else if (kind <= 6) et = ETH_VLAN;
    else if (kind == 7) et = 16'($urandom);
    else et = $urandom_range(0, 1) ? ETH_IPV4 : ETH_VLAN;
    ip = (et == ETH_VLAN) ? IP_OFS_TAGGED : IP_OFS_UNTAGGED;
    if (kind == 8) len = $urandom_range(1, 17);
    else if (kind == 9) len = $urandom_range(64, 90);
    else if ($urandom_range(0, 4) == 0) len = $urandom_range(14, ip + 34);
    else len = $urandom_range(ip + 24, ip + 44);
    frame_buf = {};
    for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom));
    if (kind != 8) stamp_headers(et, inner, proto, 8'($urandom));
  endtask

  function automatic result_t typed_hdr(logic [47:0] m1, logic [47:0] m2,
                                        logic [15:0] et, logic [1:0] st);
    result_t r;
    r = '0;
    r.mac_first  = m1;
    r.mac_second = m2;
    r.ether_type = et;
    r.status     = st;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    frame_recipe_t rc;
    // Drive every input to a known value and hold reset.
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    data_byte <= 8'h00;
    last_byte <= 1'b0;
    idle_on   <= 1'b1;
    err_count   = 0;
    bytes_taken = 0;
    frames_sent = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (hdr_store[i]) hdr_store[i] = 8'h00;
    hdr_pos = '0;

    // len, random fill, fill byte, ethertype, inner ethertype, protocol,
    // TCP flag byte, typed result
    recipes = '{
      // one-byte frame: only the first MAC byte is known
      '{1,   1'b0, 8'hFF, 16'hFFFF, 16'h0000, 8'hFF, 8'hFF, 1'b1,
        typed_hdr(48'hFF00_0000_0000, 48'h0, 16'h0, STATUS_NOT_PARSED)},
      // all-zero frame: ethertype 0, nothing parsed
      '{64,  1'b0, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b1,
        typed_hdr(48'h0, 48'h0, 16'h0, STATUS_NOT_PARSED)},
      // all-ones frame: other ethertype, MACs and outer ethertype only
      '{64,  1'b0, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1,
        typed_hdr(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, STATUS_NOT_PARSED)},
      // ends right before the ethertype
      '{12,  1'b1, 8'h00, ETH_IPV4, 16'h0000, PROTO_TCP, 8'h00, 1'b0, '0},
      // ends after the ethertype high byte, which still reads as IPv4
      '{13,  1'b0, 8'h5A, ETH_IPV4, 16'h0000, PROTO_TCP, 8'h00, 1'b0, '0},
      '{54,  1'b1, 8'h00, ETH_IPV4, 16'h0000, PROTO_TCP, 8'h17, 1'b0, '0},
      '{42,  1'b1, 8'h00, ETH_IPV4, 16'h0000, PROTO_UDP, 8'h00, 1'b0, '0},
      '{34,  1'b1, 8'h00, ETH_IPV4, 16'h0000, 8'h01,     8'h00, 1'b0, '0},
      // tagged TCP: flag byte is the last stored header byte
      '{58,  1'b1, 8'h00, ETH_VLAN, ETH_IPV4, PROTO_TCP, 8'hFF, 1'b0, '0},
      '{46,  1'b1, 8'h00, ETH_VLAN, ETH_IPV4, PROTO_UDP, 8'h00, 1'b0, '0},
      // tagged with a non-IPv4 inner ethertype: parsed at offset 18 anyway
      '{60,  1'b1, 8'h00, ETH_VLAN, 16'h86DD, PROTO_TCP, 8'hEF, 1'b0, '0},
      // tagged UDP cut before the ports
      '{30,  1'b1, 8'h00, ETH_VLAN, ETH_IPV4, PROTO_UDP, 8'h00, 1'b0, '0},
      // long frame: position saturates, trailing bytes dropped
      '{100, 1'b1, 8'h00, ETH_IPV4, 16'h0000, PROTO_TCP, 8'h10, 1'b0, '0},
      '{60,  1'b1, 8'h00, 16'h86DD, 16'h0000, PROTO_TCP, 8'hFF, 1'b0, '0},
      // TCP cut after the ports, before the flags
      '{38,  1'b1, 8'h00, ETH_IPV4, 16'h0000, PROTO_TCP, 8'hFF, 1'b0, '0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed frames.
    foreach (recipes[r]) begin
      rc = recipes[r];
      frame_buf = {};
      for (int i = 0; i < rc.len; i++) frame_buf.push_back(rc.rnd ? 8'($urandom) : rc.fill);
      stamp_headers(rc.etype, rc.inner, rc.proto, rc.tflags);
      send_frame(rc.known, rc.val);
    end
    // Pause the sender until the block has handed back every result.
    hold_until_drained();

    // Random frames; drain now and then so a quiet block is also exercised.
    while (bytes_taken < 520) begin
      build_random_frame();
      send_frame(1'b0, '0);
      if ($urandom_range(0, 14) == 0) hold_until_drained();
    end

    // Closing stretch at full rate: no gaps and no stalls.
    idle_on <= 1'b0;
    repeat (10) begin
      build_random_frame();
      send_frame(1'b0, '0);
    end

    // Wait out the last results and the output register.
    hold_until_drained();
    repeat (4) @(posedge clk);
    while (hdr_expect.size() != 0) begin
      flag_mismatch("result never came, status", 0, hdr_expect[0].status);
      void'(hdr_expect.pop_front());
    end

    $display("sent %0d frames, %0d bytes; checked %0d untagged IPv4, %0d VLAN tagged,",
             frames_sent, bytes_taken, status_seen[STATUS_UNTAGGED],
             status_seen[STATUS_TAGGED]);
    $display("%0d unparsed results, with gaps and stalls on both sides", 
             status_seen[STATUS_NOT_PARSED]);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/evlx_pkg.sv
hdl/evlx_capture.sv
hdl/evlx_extract.sv
hdl/evlx_out_buf.sv
hdl/eth_vlan_ipv4_l4_header_extract_core.sv
hdl/evlx_checker.sv
test/eth_vlan_ipv4_l4_header_extract_core_tb.sv
